@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/gbl_pkg.sv @@
// shared constants, types and the divider step for the geoid grid lookup
package gbl_pkg;

  localparam int GRID_ENTRIES = 4096;
  localparam int ADDR_BITS    = $clog2(GRID_ENTRIES);
  localparam int VALUE_BITS   = 18;
  localparam int FRAC_BITS    = 15;
  localparam int OFF_BITS     = 32;
  localparam int SPACING_BITS = 31;
  localparam int TOTAL_BITS   = 13;
  localparam int QUO_BITS     = OFF_BITS + FRAC_BITS;
  localparam int WEIGHT_BITS  = 2 * FRAC_BITS + 1;
  localparam int PROD_BITS    = WEIGHT_BITS + 1 + VALUE_BITS;
  localparam int SUM_BITS     = PROD_BITS + 2;

  typedef enum logic [3:0] {
    CFG_LAT_LOW     = 4'd0,
    CFG_LAT_HIGH    = 4'd1,
    CFG_LON_LOW     = 4'd2,
    CFG_LON_HIGH    = 4'd3,
    CFG_LAT_SPACING = 4'd4,
    CFG_LON_SPACING = 4'd5,
    CFG_ROW_TOTAL   = 4'd6,
    CFG_COL_TOTAL   = 4'd7
  } cfg_index_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    logic                  valid;
    op_t                   op;
    logic                  ok;
    logic [ADDR_BITS-1:0]  widx;
    logic [VALUE_BITS-1:0] wval;
  } side_t;

  // one restoring step: returns quotient bit and new remainder
  function automatic logic [SPACING_BITS:0] div_step(
    input logic [SPACING_BITS-1:0] rem,
    input logic                    din,
    input logic [SPACING_BITS-1:0] dv
  );
    logic [SPACING_BITS:0] t;
    logic [SPACING_BITS:0] d;
    logic [SPACING_BITS:0] r;
    t = {rem, din};
    d = {1'b0, dv};
    if (t >= d) begin
      r = t - d;
      div_step = {1'b1, r[SPACING_BITS-1:0]};
    end else begin
      div_step = {1'b0, t[SPACING_BITS-1:0]};
    end
  endfunction

endpackage

@@ rtl/gbl_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module gbl_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic [gbl_pkg::OFF_BITS-1:0]      dividend,
  input  logic [gbl_pkg::SPACING_BITS-1:0]  divisor,
  output logic [gbl_pkg::QUO_BITS-1:0]      quotient
);

  localparam int N  = gbl_pkg::QUO_BITS;
  localparam int SB = gbl_pkg::SPACING_BITS;
  localparam int OB = gbl_pkg::OFF_BITS;

  logic [SB-1:0] rem_s [1:N];
  logic [OB-1:0] dvd_s [1:N];
  logic [N-1:0]  quo_s [1:N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    if (k == 0) begin : g_first
      logic [SB:0] st;
      assign st = gbl_pkg::div_step('0, dividend[OB-1], divisor);
      always_ff @(posedge clk) begin
        if (en) begin
          rem_s[1] <= st[SB-1:0];
          dvd_s[1] <= {dividend[OB-2:0], 1'b0};
          quo_s[1] <= {{(N-1){1'b0}}, st[SB]};
        end
      end
    end else begin : g_rest
      logic [SB:0] st;
      assign st = gbl_pkg::div_step(rem_s[k], dvd_s[k][OB-1], divisor);
      always_ff @(posedge clk) begin
        if (en) begin
          rem_s[k+1] <= st[SB-1:0];
          dvd_s[k+1] <= {dvd_s[k][OB-2:0], 1'b0};
          quo_s[k+1] <= {quo_s[k][N-2:0], st[SB]};
        end
      end
    end
  end

  assign quotient = quo_s[N];

endmodule

@@ rtl/geoid_grid_bilinear_lookup.sv @@
// top level: bilinear lookup in a row-major grid of geoid undulation values
// path: input stage, two 47-stage dividers, then clamp, weight, memory, product and output registers
// throughput: one transaction per cycle while the output skid is empty, writes and queries alike
// grid memory is two copies, each read at two addresses per cycle
// reset sets control and configuration to their defaults; grid contents are undefined until written
module geoid_grid_bilinear_lookup (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,  // entry_index, entry_value, query_lat, query_lon
  input  logic [0:0]  s_tuser,  // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // undulation
  output logic [0:0]  m_tuser,  // covered
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AB = gbl_pkg::ADDR_BITS;
  localparam int VB = gbl_pkg::VALUE_BITS;
  localparam int FB = gbl_pkg::FRAC_BITS;
  localparam int OB = gbl_pkg::OFF_BITS;
  localparam int SB = gbl_pkg::SPACING_BITS;
  localparam int TB = gbl_pkg::TOTAL_BITS;
  localparam int QB = gbl_pkg::QUO_BITS;
  localparam int WB = gbl_pkg::WEIGHT_BITS;
  localparam int PB = gbl_pkg::PROD_BITS;
  localparam int SUMB = gbl_pkg::SUM_BITS;
  localparam int DEPTH = gbl_pkg::GRID_ENTRIES;

  // configuration
  logic signed [31:0] lat_low, lat_high, lon_low, lon_high;
  logic [SB-1:0] lat_spacing, lon_spacing;
  logic [TB-1:0] row_total, col_total;
  logic          grid_ok;
  logic [2*TB-1:0] grid_size;

  assign cfg_ready = 1'b1;
  assign grid_size = row_total * col_total;
  assign grid_ok   = (row_total != '0) && (col_total != '0) && (lat_spacing != '0) &&
                     (lon_spacing != '0) && (grid_size <= (2*TB)'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_low     <= '0;
      lat_high    <= '0;
      lon_low     <= '0;
      lon_high    <= '0;
      lat_spacing <= SB'(4194304);
      lon_spacing <= SB'(4194304);
      row_total   <= TB'(1);
      col_total   <= TB'(1);
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          gbl_pkg::CFG_LAT_LOW:     lat_low     <= cfg_data;
          gbl_pkg::CFG_LAT_HIGH:    lat_high    <= cfg_data;
          gbl_pkg::CFG_LON_LOW:     lon_low     <= cfg_data;
          gbl_pkg::CFG_LON_HIGH:    lon_high    <= cfg_data;
          gbl_pkg::CFG_LAT_SPACING: lat_spacing <= cfg_data[SB-1:0];
          gbl_pkg::CFG_LON_SPACING: lon_spacing <= cfg_data[SB-1:0];
          gbl_pkg::CFG_ROW_TOTAL:   row_total   <= cfg_data[TB-1:0];
          gbl_pkg::CFG_COL_TOTAL:   col_total   <= cfg_data[TB-1:0];
          default: ;
        endcase
      end
    end
  end

  // flow control
  logic en, skid_valid;
  assign en       = !skid_valid;
  assign s_tready = en;

  // input stage
  logic signed [31:0] q_lat, q_lon;
  logic [32:0] lat_diff, lon_diff;
  logic in_ok;
  gbl_pkg::side_t side_in;
  gbl_pkg::side_t side_d [0:QB];
  logic [OB-1:0] off_lat, off_lon;

  assign q_lat = s_tdata[61:30];
  assign q_lon = s_tdata[93:62];
  assign lat_diff = {q_lat[31], q_lat} - {lat_low[31], lat_low};
  assign lon_diff = {q_lon[31], q_lon} - {lon_low[31], lon_low};
  assign in_ok = grid_ok && (q_lat >= lat_low) && (q_lat <= lat_high) &&
                 (q_lon >= lon_low) && (q_lon <= lon_high);

  always_comb begin
    side_in.valid = s_tvalid && s_tready;
    side_in.op    = gbl_pkg::op_t'(s_tuser[0]);
    side_in.ok    = in_ok;
    side_in.widx  = s_tdata[AB-1:0];
    side_in.wval  = s_tdata[29:12];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_d[0] <= '0;
    end else if (en) begin
      side_d[0] <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off_lat <= lat_diff[OB-1:0];
      off_lon <= lon_diff[OB-1:0];
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        side_d[k+1] <= '0;
      end else if (en) begin
        side_d[k+1] <= side_d[k];
      end
    end
  end

  // dividers
  logic [QB-1:0] quo_lat, quo_lon;

  gbl_div u_div_lat (
    .clk      (clk),
    .en       (en),
    .dividend (off_lat),
    .divisor  (lat_spacing),
    .quotient (quo_lat)
  );

  gbl_div u_div_lon (
    .clk      (clk),
    .en       (en),
    .dividend (off_lon),
    .divisor  (lon_spacing),
    .quotient (quo_lon)
  );

  // clamp stage
  logic [TB-1:0] last_r, last_c;
  logic [OB-1:0] qi_lat, qi_lon;
  logic [TB-1:0] r0_c, c0_c, r0p, c0p;
  gbl_pkg::side_t side1, side2, side3, side4;
  logic [AB-1:0] r0, r1, c0, c1;
  logic [FB-1:0] fr, fc;

  assign last_r = row_total - TB'(1);
  assign last_c = col_total - TB'(1);
  assign qi_lat = quo_lat[QB-1:FB];
  assign qi_lon = quo_lon[QB-1:FB];
  assign r0_c = (qi_lat > OB'(last_r)) ? last_r : qi_lat[TB-1:0];
  assign c0_c = (qi_lon > OB'(last_c)) ? last_c : qi_lon[TB-1:0];
  assign r0p  = r0_c + TB'(1);
  assign c0p  = c0_c + TB'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      side1 <= '0;
    end else if (en) begin
      side1 <= side_d[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0 <= r0_c[AB-1:0];
      c0 <= c0_c[AB-1:0];
      r1 <= (r0p > last_r) ? last_r[AB-1:0] : r0p[AB-1:0];
      c1 <= (c0p > last_c) ? last_c[AB-1:0] : c0p[AB-1:0];
      fr <= quo_lat[FB-1:0];
      fc <= quo_lon[FB-1:0];
    end
  end

  // row base and weight stage
  logic [FB:0] wr0, wc0;
  logic [AB+TB-1:0] br0_full, br1_full;
  logic [AB-1:0] br0, br1, c0_2, c1_2;
  logic [2*FB+1:0] w00_full, w01_full, w10_full, w11_full;
  logic [WB-1:0] w00, w01, w10, w11;

  assign wr0 = (FB+1)'(1 << FB) - {1'b0, fr};
  assign wc0 = (FB+1)'(1 << FB) - {1'b0, fc};
  assign br0_full = r0 * col_total;
  assign br1_full = r1 * col_total;
  assign w00_full = wr0 * wc0;
  assign w01_full = wr0 * {1'b0, fc};
  assign w10_full = {1'b0, fr} * wc0;
  assign w11_full = {1'b0, fr} * {1'b0, fc};

  always_ff @(posedge clk) begin
    if (rst) begin
      side2 <= '0;
    end else if (en) begin
      side2 <= side1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      br0  <= br0_full[AB-1:0];
      br1  <= br1_full[AB-1:0];
      c0_2 <= c0;
      c1_2 <= c1;
      w00  <= w00_full[WB-1:0];
      w01  <= w01_full[WB-1:0];
      w10  <= w10_full[WB-1:0];
      w11  <= w11_full[WB-1:0];
    end
  end

  // memory stage: writes and reads stay in transaction order
  logic [VB-1:0] mem_a [DEPTH];
  logic [VB-1:0] mem_b [DEPTH];
  logic [AB-1:0] a00, a01, a10, a11;
  logic signed [VB-1:0] v00, v01, v10, v11;
  logic [WB-1:0] w00_3, w01_3, w10_3, w11_3;
  logic mem_wr;

  assign a00 = br0 + c0_2;
  assign a01 = br0 + c1_2;
  assign a10 = br1 + c0_2;
  assign a11 = br1 + c1_2;
  assign mem_wr = en && side2.valid && (side2.op == gbl_pkg::OP_WRITE);

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem_a[side2.widx] <= side2.wval;
      mem_b[side2.widx] <= side2.wval;
    end
    if (en) begin
      v00 <= mem_a[a00];
      v01 <= mem_a[a01];
      v10 <= mem_b[a10];
      v11 <= mem_b[a11];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side3 <= '0;
    end else if (en) begin
      side3 <= side2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w00_3 <= w00;
      w01_3 <= w01;
      w10_3 <= w10;
      w11_3 <= w11;
    end
  end

  // product stage
  logic signed [PB-1:0] p00, p01, p10, p11;

  always_ff @(posedge clk) begin
    if (rst) begin
      side4 <= '0;
    end else if (en) begin
      side4 <= side3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= $signed({1'b0, w00_3}) * v00;
      p01 <= $signed({1'b0, w01_3}) * v01;
      p10 <= $signed({1'b0, w10_3}) * v10;
      p11 <= $signed({1'b0, w11_3}) * v11;
    end
  end

  // sum, round and output with skid
  logic signed [SUMB-1:0] sum;
  logic produce;
  logic [VB-1:0] res_val;
  logic res_cov;
  logic [VB-1:0] skid_val;
  logic skid_cov;

  assign sum = SUMB'(p00) + SUMB'(p01) + SUMB'(p10) + SUMB'(p11) +
               SUMB'(1 << (2*FB - 1));
  assign produce = en && side4.valid && (side4.op == gbl_pkg::OP_QUERY);
  assign res_cov = side4.ok;
  assign res_val = side4.ok ? sum[2*FB+VB-1:2*FB] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tdata <= {{(24-VB){1'b0}}, skid_val};
        m_tuser <= skid_cov;
      end else begin
        m_tdata <= {{(24-VB){1'b0}}, res_val};
        m_tuser <= res_cov;
      end
    end else if (produce) begin
      skid_val <= res_val;
      skid_cov <= res_cov;
    end
  end

  `include "assert_macros.svh"

  `ASSERT_IMPL(a_skid_has_out, skid_valid, m_tvalid)
  `ASSERT_IMPL(a_uncovered_zero, m_tvalid && !m_tuser[0], m_tdata == '0)
  `ASSERT_NEXT(a_skid_only_stalled, !skid_valid && (!m_tvalid || m_tready), !skid_valid)

endmodule
